// File: src/head_verify_length_tail_deframer_top_defines.svh
// Assertion macros used by the checker file.
`ifndef HEAD_VERIFY_LENGTH_TAIL_DEFRAMER_TOP_DEFINES_SVH
`define HEAD_VERIFY_LENGTH_TAIL_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define HVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, off while reset is held.
`define HVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication that also watches reset itself.
`define HVD_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer reset check failed");

`endif

// File: src/hvd_pkg.sv
`default_nettype none
package hvd_pkg;

    localparam logic [7:0]  HEAD_BYTE     = 8'hFF;
    localparam logic [7:0]  TAIL_BYTE     = 8'hFE;
    localparam int          VERIFY_LEN    = 4;
    localparam int          HDR_LEN       = 11;
    localparam int          OVERHEAD      = 12;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
    localparam int          QDEPTH        = 4;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD_END = 2'd1;
    localparam logic [1:0] KIND_BAD_TAIL = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  seq_num;
        logic [7:0]  command;
        logic [31:0] payload_len;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Verify code "ABCD"
    function automatic logic [7:0] verify_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h41;
            2'd1:    v = 8'h42;
            2'd2:    v = 8'h43;
            default: v = 8'h44;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/hvd_front.sv
`default_nettype none
module hvd_front import hvd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_rx_valid,
    input  wire logic [7:0]  i_rx_byte,
    input  wire t_q_stat     i_q_stat,
    output t_result          o_push_data,
    output logic             o_push,
    output logic             o_rx_stall
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_VERIFY  = 3'd1;
    localparam logic [2:0] PH_SEQ     = 3'd2;
    localparam logic [2:0] PH_CMD     = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_TAIL    = 3'd6;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_byte_pos, n_byte_pos;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_len, n_len;
    logic [15:0] r_total, n_total;
    logic [15:0] r_max;

    logic        accept;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_data;
    logic [32:0] whole;
    logic [16:0] pos_plus;

    assign o_rx_stall = i_q_stat.full;
    assign accept     = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_phase    = r_phase;
        n_byte_pos = r_byte_pos;
        n_seq      = r_seq;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_total    = r_total;
        emit       = 1'b0;
        emit_kind  = KIND_PAYLOAD;
        emit_data  = 8'd0;
        whole      = {1'b0, n_len} + 33'(OVERHEAD);
        pos_plus   = {1'b0, r_byte_pos} + 17'd2;
        case (r_phase)
            PH_VERIFY: begin
                if (r_byte_pos >= 16'd1 && r_byte_pos <= 16'(VERIFY_LEN) &&
                    i_rx_byte == verify_byte(2'(r_byte_pos - 16'd1))) begin
                    n_byte_pos = r_byte_pos + 16'd1;
                    if (n_byte_pos == 16'(VERIFY_LEN + 1)) begin
                        n_phase = PH_SEQ;
                    end
                end else if (i_rx_byte == HEAD_BYTE) begin
                    // restart the match on a fresh head
                    n_byte_pos = 16'd1;
                end else begin
                    n_byte_pos = 16'd0;
                    n_phase    = PH_HUNT;
                end
            end
            PH_SEQ: begin
                n_seq      = i_rx_byte;
                n_byte_pos = r_byte_pos + 16'd1;
                n_phase    = PH_CMD;
            end
            PH_CMD: begin
                n_cmd      = i_rx_byte;
                n_byte_pos = r_byte_pos + 16'd1;
                n_phase    = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len      = {i_rx_byte, r_len[31:8]};
                n_byte_pos = r_byte_pos + 16'd1;
                whole      = {1'b0, n_len} + 33'(OVERHEAD);
                if (n_byte_pos == 16'(HDR_LEN)) begin
                    if (whole > {17'd0, r_max}) begin
                        n_phase    = PH_HUNT;
                        n_byte_pos = 16'd0;
                        emit       = 1'b1;
                        emit_kind  = KIND_TOO_LONG;
                    end else begin
                        n_total = whole[15:0];
                        n_phase = (n_len == 32'd0) ? PH_TAIL : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_byte_pos = r_byte_pos + 16'd1;
                // new position plus one reaches the total: next byte is the tail
                if (pos_plus >= {1'b0, r_total}) begin
                    n_phase = PH_TAIL;
                end
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                emit_data = i_rx_byte;
            end
            PH_TAIL: begin
                n_phase    = PH_HUNT;
                n_byte_pos = 16'd0;
                emit       = 1'b1;
                emit_kind  = (i_rx_byte == TAIL_BYTE) ? KIND_GOOD_END : KIND_BAD_TAIL;
            end
            default: begin
                if (i_rx_byte == HEAD_BYTE) begin
                    n_byte_pos = 16'd1;
                    n_phase    = PH_VERIFY;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    assign o_push                  = accept && emit;
    assign o_push_data.kind        = emit_kind;
    assign o_push_data.data_byte   = emit_data;
    assign o_push_data.seq_num     = n_seq;
    assign o_push_data.command     = n_cmd;
    assign o_push_data.payload_len = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_byte_pos <= 16'd0;
            r_seq      <= 8'd0;
            r_cmd      <= 8'd0;
            r_len      <= 32'd0;
            r_total    <= 16'd0;
            r_max      <= MAX_LEN_RESET;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_byte_pos <= n_byte_pos;
                r_seq      <= n_seq;
                r_cmd      <= n_cmd;
                r_len      <= n_len;
                r_total    <= n_total;
            end
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/hvd_queue.sv
`default_nettype none
module hvd_queue import hvd_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    input  wire logic    i_pop,
    output t_result      o_rd_data,
    output t_q_stat      o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rd_data    = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/hvd_back.sv
`default_nettype none
module hvd_back import hvd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_result i_q_data,
    input  wire logic    i_stall,
    output logic         o_pop,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Load the output register whenever it is empty or being taken
    assign o_pop   = !i_q_stat.empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: src/head_verify_length_tail_deframer_top.sv
// Byte-stream packet deframer with sync header.
// Input channel: i_rx_valid / o_rx_stall carry one received byte (i_rx_byte)
// per transaction. A packet is head 0xFF, verify "ABCD", seq, cmd, a 4-byte
// little-endian length N, N payload bytes and a closing byte.
// Output channel: o_valid / i_stall carry one result per transaction: a
// payload byte, a good end (closing byte 0xFE), a bad tail, or too long
// (N + 12 over max_packet_len), together with the packet's seq, cmd and N.
// Header bytes and hunting bytes give no result.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into max_packet_len.
// Throughput: one byte per cycle while o_rx_stall is low; the parser state
// updates in the cycle a byte is taken.
// A result is written to the queue at the accepting edge and moves into the
// output register when that register is empty or its result is being taken.
// When the receiver stalls, the output register holds its transaction and
// the queue absorbs QUEUE_DEPTH more results; o_rx_stall rises once it is
// full and drops as soon as an entry is drained.
// Reset (synchronous, active low) returns the parser to hunting, clears the
// captured fields, sets max_packet_len to 4096 and empties the queue.
`default_nettype none
module head_verify_length_tail_deframer_top import hvd_pkg::*; #(
    parameter int QUEUE_DEPTH = QDEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_seq_num,
    output logic [7:0]       o_command,
    output logic [31:0]      o_payload_len
);

    t_result push_data;
    t_result q_data;
    t_result out_res;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    // Front: parse and classify each byte, push results
    hvd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_rx_valid   (i_rx_valid),
        .i_rx_byte    (i_rx_byte),
        .i_q_stat     (q_stat),
        .o_push_data  (push_data),
        .o_push       (push),
        .o_rx_stall   (o_rx_stall)
    );

    // Short queue decoupling parser from receiver stalls
    hvd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_rd_data  (q_data),
        .o_stat     (q_stat)
    );

    // Back: registered output transaction
    hvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_stat(q_stat),
        .i_q_data(q_data),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_data_byte   = out_res.data_byte;
    assign o_seq_num     = out_res.seq_num;
    assign o_command     = out_res.command;
    assign o_payload_len = out_res.payload_len;

endmodule
`default_nettype wire

// File: src/hvd_checker.sv
`default_nettype none
`include "head_verify_length_tail_deframer_top_defines.svh"
module hvd_checker import hvd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_rx_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic [7:0]  o_seq_num,
    input wire logic [7:0]  o_command,
    input wire logic [31:0] o_payload_len
);

    logic [57:0] out_fields;

    assign out_fields = {o_kind, o_data_byte, o_seq_num, o_command, o_payload_len};

    // Stalled output transaction holds
    `HVD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_fields))
    // Only payload results carry a data byte
    `HVD_ASSERT_IMP(a_data_zero, i_clk, i_rst_n, o_valid && (o_kind != KIND_PAYLOAD), o_data_byte == 8'd0)
    // Payload bytes only come from packets with a nonzero length
    `HVD_ASSERT_IMP(a_payload_len, i_clk, i_rst_n, o_valid && (o_kind == KIND_PAYLOAD), o_payload_len != 32'd0)
    // Reset empties the output and the queue
    `HVD_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_rx_stall)

endmodule

bind head_verify_length_tail_deframer_top hvd_checker u_hvd_checker (.*);
`default_nettype wire

// File: sim/tb_head_verify_length_tail_deframer_top.sv
`timescale 1ns / 1ps

module tb_head_verify_length_tail_deframer_top;
    import hvd_pkg::*;

    // Bound the run; a healthy run ends far below this.
    localparam int CYCLE_LIMIT = 200_000;
    // Cap the number of printed mismatch lines.
    localparam int REPORT_CAP = 200;
    // Sync word that must follow the head byte.
    localparam logic [31:0] SYNC_CHARS = "ABCD";

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_VERIFY  = 3'd1,
        ST_SEQ     = 3'd2,
        ST_CMD     = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_PAYLOAD = 3'd5,
        ST_TAIL    = 3'd6
    } parse_state_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_seq_num;
    logic [7:0]  o_command;
    logic [31:0] o_payload_len;

    head_verify_length_tail_deframer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_seq_num     (o_seq_num),
        .o_command     (o_command),
        .o_payload_len (o_payload_len)
    );

    // 2 ns clock: one delay high, one delay low.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the parser state and the length limit.
    parse_state_e frame_state = ST_HUNT;
    logic [15:0]  frame_pos   = '0;
    logic [7:0]   frame_seq   = '0;
    logic [7:0]   frame_cmd   = '0;
    logic [31:0]  frame_len   = '0;
    logic [15:0]  frame_total = '0;
    logic [15:0]  limit_len   = MAX_LEN_RESET;

    // Deframer results still owed by the block, oldest first.
    t_result pending_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int payload_seen  = 0;
    int good_ends     = 0;
    int bad_tails     = 0;
    int oversize_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Character idx of the sync word ('A' is 0).
    function automatic logic [7:0] sync_char(input int idx);
        return SYNC_CHARS[31 - 8 * idx -: 8];
    endfunction

    // Advance the parser by one accepted byte; return 1 when it yields a result.
    function automatic bit predict_deframe(input logic [7:0] b, output t_result r);
        logic [32:0] whole;
        bit          emitted;
        emitted = 1'b0;
        r       = '0;
        whole   = '0;
        case (frame_state)
            ST_VERIFY: begin
                if (frame_pos >= 1 && frame_pos <= VERIFY_LEN &&
                    b == sync_char(int'(frame_pos) - 1)) begin
                    frame_pos = frame_pos + 16'd1;
                    if (frame_pos == VERIFY_LEN + 1)
                        frame_state = ST_SEQ;
                end else if (b == HEAD_BYTE) begin
                    // a head byte restarts the sync match
                    frame_pos = 16'd1;
                end else begin
                    frame_pos   = '0;
                    frame_state = ST_HUNT;
                end
            end
            ST_SEQ: begin
                frame_seq   = b;
                frame_pos   = frame_pos + 16'd1;
                frame_state = ST_CMD;
            end
            ST_CMD: begin
                frame_cmd   = b;
                frame_pos   = frame_pos + 16'd1;
                frame_state = ST_LENGTH;
            end
            ST_LENGTH: begin
                // little-endian: shift the newest byte in at the top
                frame_len = {b, frame_len[31:8]};
                frame_pos = frame_pos + 16'd1;
                if (frame_pos >= HDR_LEN) begin
                    // no wrap: lengths near 2^32 stay over the limit
                    whole = {1'b0, frame_len} + 33'(OVERHEAD);
                    if (whole > {17'd0, limit_len}) begin
                        frame_state = ST_HUNT;
                        frame_pos   = '0;
                        r.kind      = KIND_TOO_LONG;
                        emitted     = 1'b1;
                    end else begin
                        frame_total = whole[15:0];
                        frame_state = (frame_len == 0) ? ST_TAIL : ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                frame_pos = frame_pos + 16'd1;
                if ({16'd0, frame_pos} + 32'd1 >= {16'd0, frame_total})
                    frame_state = ST_TAIL;
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
                emitted     = 1'b1;
            end
            ST_TAIL: begin
                frame_state = ST_HUNT;
                frame_pos   = '0;
                r.kind      = (b == TAIL_BYTE) ? KIND_GOOD_END : KIND_BAD_TAIL;
                emitted     = 1'b1;
            end
            default: begin
                // hunt, and the unused phase code behaves the same
                if (b == HEAD_BYTE) begin
                    frame_pos   = 16'd1;
                    frame_state = ST_VERIFY;
                end else begin
                    frame_state = ST_HUNT;
                end
            end
        endcase
        r.seq_num     = frame_seq;
        r.command     = frame_cmd;
        r.payload_len = frame_len;
        return emitted;
    endfunction

    // Receiver side: stall at random at the current rate.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: end the run once the cycle limit is reached.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_results.size());
            $display("tb_head_verify_length_tail_deframer_top: errors");
            $finish;
        end
    end

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= REPORT_CAP)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
        end
    endtask

    // Check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            case (o_kind)
                KIND_PAYLOAD:  payload_seen++;
                KIND_GOOD_END: good_ends++;
                KIND_BAD_TAIL: bad_tails++;
                default:       oversize_seen++;
            endcase
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t: unexpected result: expected none, got kind %0d data 0x%0h",
                             $time, o_kind, o_data_byte);
            end else begin
                want = pending_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_kind));
                compare_field("data_byte", 32'(want.data_byte), 32'(o_data_byte));
                compare_field("seq_num", 32'(want.seq_num), 32'(o_seq_num));
                compare_field("command", 32'(want.command), 32'(o_command));
                compare_field("payload_len", want.payload_len, o_payload_len);
            end
        end
    end

    // Send one byte transaction; idle first at the current rate, then hold
    // the byte until it is taken and predict what it causes.
    task automatic send_rx_byte(input logic [7:0] b);
        t_result r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
        items_sent++;
        if (predict_deframe(b, r))
            pending_results.push_back(r);
    endtask

    // Drop valid and hold off until every owed result has come out.
    task automatic wait_results_drained();
        i_rx_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // let any header byte still in flight settle
        repeat (4) @(posedge i_clk);
    endtask

    // Write max_packet_len only once the block is idle.
    task automatic write_max_len(input logic [15:0] value);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_len = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Head, sync word, seq, cmd and the little-endian length.
    task automatic send_header(input logic [7:0] seq, input logic [7:0] cmd,
                               input logic [31:0] n);
        send_rx_byte(HEAD_BYTE);
        for (int i = 0; i < VERIFY_LEN; i++)
            send_rx_byte(sync_char(i));
        send_rx_byte(seq);
        send_rx_byte(cmd);
        for (int i = 0; i < 4; i++)
            send_rx_byte(n[8 * i +: 8]);
    endtask

    // Whole packet with random payload; follow the parser so that a length
    // over the limit sends no body.
    task automatic send_packet(input logic [7:0] seq, input logic [7:0] cmd,
                               input logic [31:0] n, input logic [7:0] tail);
        send_header(seq, cmd, n);
        while (frame_state == ST_PAYLOAD)
            send_rx_byte(8'($urandom_range(0, 255)));
        if (frame_state == ST_TAIL)
            send_rx_byte(tail);
    endtask

    // Short burst of line noise, biased toward head and sync characters.
    task automatic send_noise();
        int count;
        int pick;
        count = $urandom_range(1, 6);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_rx_byte(HEAD_BYTE);
            else if (pick < 45)
                send_rx_byte(sync_char($urandom_range(0, 3)));
            else
                send_rx_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Head and a partial sync word broken by a wrong character.
    task automatic send_broken_header();
        int         good;
        logic [7:0] wrong;
        good = $urandom_range(0, VERIFY_LEN - 1);
        send_rx_byte(HEAD_BYTE);
        for (int i = 0; i < good; i++)
            send_rx_byte(sync_char(i));
        wrong = 8'($urandom_range(0, 255));
        if (wrong == sync_char(good))
            wrong = wrong ^ 8'h01;
        send_rx_byte(wrong);
    endtask

    // A head inside the sync match restarts it; empty payload, good end.
    task automatic test_head_restart_empty_payload();
        send_rx_byte(HEAD_BYTE);
        send_rx_byte(sync_char(0));
        send_packet(8'h00, 8'hFF, 32'd0, TAIL_BYTE);
    endtask

    // Length near 2^32 is too long; hunting resumes right after.
    task automatic test_length_over_limit();
        send_header(8'hFF, 8'h00, 32'hFFFF_FFFF);
    endtask

    // Payload of 0x00 and 0xFF closed by a wrong tail byte.
    task automatic test_bad_tail_after_payload();
        send_header(8'h5A, 8'hA5, 32'd2);
        send_rx_byte(8'h00);
        send_rx_byte(HEAD_BYTE);
        send_rx_byte(8'h00);
    endtask

    // Mostly well-formed packets with random content under one limit, mixed
    // with noise and broken headers; lengths hug the limit on both sides.
    task automatic test_random_stream(input logic [15:0] max_len, input int n_items);
        int          stop_at;
        int          pick;
        int          room;
        int          cap;
        logic [31:0] n;
        logic [7:0]  tail;
        write_max_len(max_len);
        stop_at = items_sent + n_items;
        room    = int'(limit_len) - OVERHEAD;
        cap     = (room < 16) ? room : 16;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_noise();
            end else if (pick < 22) begin
                send_broken_header();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10 && room <= 48)
                    n = 32'(room);                         // exactly at the limit
                else if (pick < 20)
                    n = 32'(room + 1);                     // one byte over
                else if (pick < 25)
                    n = 32'hFFFF_FFF4 + $urandom_range(0, 11);  // sum would wrap
                else if (pick < 30)
                    n = $urandom();
                else
                    n = $urandom_range(cap, 0);
                tail = ($urandom_range(0, 99) < 85) ? TAIL_BYTE : 8'($urandom_range(0, 255));
                send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n, tail);
            end
        end
    endtask

    initial begin
        logic [15:0] mid_len;
        mid_len = 16'($urandom_range(13, 300));

        // Hold reset at the start, once.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit, sender and receiver both idling.
        set_idling(31, 48);
        test_head_restart_empty_payload();
        test_length_over_limit();
        test_bad_tail_after_payload();

        // Smallest limit, where only empty payloads fit, then a limit of 40.
        test_random_stream(16'd12, 300);
        test_random_stream(16'd40, 300);

        // Swap the idling rates; largest limit, then a random one.
        set_idling(48, 31);
        test_random_stream(16'hFFFF, 400);
        test_random_stream(mid_len, 250);

        // Full rate on both sides, back at the reset limit.
        set_idling(0, 0);
        test_random_stream(MAX_LEN_RESET, 600);

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            error_count++;

        $display("Sent %0d bytes under limits 12, 40, 65535, %0d and 4096.",
                 items_sent, mid_len);
        $display("Checked %0d payload bytes, %0d good ends, %0d bad tails, %0d oversize.",
                 payload_seen, good_ends, bad_tails, oversize_seen);
        if (error_count == 0)
            $display("tb_head_verify_length_tail_deframer_top: clean");
        else
            $display("tb_head_verify_length_tail_deframer_top: errors");
        $finish;
    end

endmodule
